// ===== hw/rtl/bpt_pkg.sv =====
// Shared types, constants and helpers for the baseline peak trigger.
package bpt_pkg;

   localparam int MAX_SAMPLES  = 32;
   localparam int MAX_CHANNELS = 256;
   localparam int MAX_PACKETS  = 32;
   localparam int HIT_LIMIT    = (MAX_PACKETS < 63) ? MAX_PACKETS : 63;

   localparam int SAMPLE_W   = 14;
   localparam int NSAMP_W    = 6;
   localparam int NCHAN_W    = 9;
   localparam int THRESH_W   = 14;
   localparam int SIDX_W     = 5;
   localparam int CIDX_W     = 8;
   localparam int LOW_W      = 16;
   localparam int HIGH_W     = 19;
   localparam int PEAK_W     = 16;
   localparam int HITS_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   localparam logic [NSAMP_W-1:0]  NSAMP_RESET  = 6'd31;
   localparam logic [NCHAN_W-1:0]  NCHAN_RESET  = 9'd64;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 14'd1500;

   localparam logic [NSAMP_W-1:0] NSAMP_MIN = 6'd6;
   localparam logic [NSAMP_W-1:0] NSAMP_MAX = NSAMP_W'(MAX_SAMPLES);
   localparam logic [NCHAN_W-1:0] NCHAN_MIN = 9'd1;
   localparam logic [NCHAN_W-1:0] NCHAN_MAX = NCHAN_W'(MAX_CHANNELS);
   localparam logic [HITS_W-1:0]  HIT_MAX   = HITS_W'(HIT_LIMIT);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLES_PER_CHANNEL = 2'd0,
      CSR_CHANNELS_PER_PACKET = 2'd1,
      CSR_PEAK_THRESHOLD      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [NSAMP_W-1:0]  samples_per_channel;
      logic [NCHAN_W-1:0]  channels_per_packet;
      logic [THRESH_W-1:0] peak_threshold;
   } cfg_type;

   typedef struct packed {
      logic [PEAK_W-1:0] peak_thirds;
      logic              over_threshold;
      logic [HITS_W-1:0] event_hit_count;
      logic              end_of_event;
   } rsp_type;

   function automatic logic [NSAMP_W-1:0] eff_samples(input logic [NSAMP_W-1:0] n);
      logic [NSAMP_W-1:0] r;
      r = n;
      if (r < NSAMP_MIN) r = NSAMP_MIN;
      if (r > NSAMP_MAX) r = NSAMP_MAX;
      return r;
   endfunction

   function automatic logic [NCHAN_W-1:0] eff_channels(input logic [NCHAN_W-1:0] n);
      logic [NCHAN_W-1:0] r;
      r = n;
      if (r < NCHAN_MIN) r = NCHAN_MIN;
      if (r > NCHAN_MAX) r = NCHAN_MAX;
      return r;
   endfunction

endpackage

// ===== hw/rtl/bpt_csr.sv =====
// Configuration registers written through the plain write port.
module bpt_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output bpt_pkg::cfg_type               cfg
);

   bpt_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bpt_pkg::CSR_SAMPLES_PER_CHANNEL:
               cfg_in.samples_per_channel = csr_wdata[bpt_pkg::NSAMP_W-1:0];
            bpt_pkg::CSR_CHANNELS_PER_PACKET:
               cfg_in.channels_per_packet = csr_wdata[bpt_pkg::NCHAN_W-1:0];
            bpt_pkg::CSR_PEAK_THRESHOLD:
               cfg_in.peak_threshold = csr_wdata[bpt_pkg::THRESH_W-1:0];
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.samples_per_channel <= bpt_pkg::NSAMP_RESET;
         cfg_ff.channels_per_packet <= bpt_pkg::NCHAN_RESET;
         cfg_ff.peak_threshold      <= bpt_pkg::THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/bpt_accum.sv =====
// Per-sample baseline, channel peak and packet peak accumulation.
module bpt_accum (
   input  logic                         clock,
   input  logic                         reset,
   input  bpt_pkg::cfg_type             cfg,
   input  logic [bpt_pkg::SAMPLE_W-1:0] sample,
   input  logic                         last_pkt,
   input  logic                         step,
   output logic                         produce,
   output bpt_pkg::rsp_type             rsp
);

   logic [bpt_pkg::SIDX_W-1:0]   sample_index_ff, sample_index_in;
   logic [bpt_pkg::CIDX_W-1:0]   channel_index_ff, channel_index_in;
   logic [bpt_pkg::LOW_W-1:0]    low_sum_ff, low_sum_in;
   logic [bpt_pkg::HIGH_W-1:0]   high_sum_ff, high_sum_in;
   logic [bpt_pkg::SAMPLE_W-1:0] chan_max_ff, chan_max_in;
   logic [bpt_pkg::PEAK_W-1:0]   packet_peak_ff, packet_peak_in;
   logic [bpt_pkg::HITS_W-1:0]   hit_count_ff, hit_count_in;

   logic [bpt_pkg::NSAMP_W-1:0]  ns;
   logic [bpt_pkg::NCHAN_W-1:0]  nc;
   logic [bpt_pkg::NSAMP_W-1:0]  sidx_ext;
   logic [bpt_pkg::LOW_W-1:0]    low_acc;
   logic [bpt_pkg::HIGH_W-1:0]   high_acc;
   logic [bpt_pkg::SAMPLE_W-1:0] max_acc;
   logic [bpt_pkg::HIGH_W-1:0]   base;
   logic [bpt_pkg::HIGH_W-1:0]   top;
   logic [bpt_pkg::PEAK_W-1:0]   pk;
   logic [bpt_pkg::PEAK_W-1:0]   peak;
   logic [bpt_pkg::PEAK_W-1:0]   thresh3;
   logic [bpt_pkg::HITS_W-1:0]   hits_after;
   logic                         chan_done;
   logic                         pkt_done;
   logic                         over;

   always_comb begin
      ns       = bpt_pkg::eff_samples(cfg.samples_per_channel);
      nc       = bpt_pkg::eff_channels(cfg.channels_per_packet);
      sidx_ext = {1'b0, sample_index_ff};

      low_acc  = low_sum_ff;
      high_acc = high_sum_ff;
      if (sidx_ext < 6'd3)
         low_acc = low_sum_ff + bpt_pkg::LOW_W'(sample);
      if (sidx_ext >= ns - 6'd3)
         high_acc = high_sum_ff + bpt_pkg::HIGH_W'(sample);
      max_acc = (sample > chan_max_ff) ? sample : chan_max_ff;

      chan_done = (sidx_ext + 6'd1) >= ns;
      pkt_done  = chan_done && ((bpt_pkg::NCHAN_W'(channel_index_ff) + 9'd1) >= nc);

      // baseline and peak stay in thirds of a count
      base = (bpt_pkg::HIGH_W'(low_acc) < high_acc) ? bpt_pkg::HIGH_W'(low_acc) : high_acc;
      top  = (bpt_pkg::HIGH_W'(max_acc) << 1) + bpt_pkg::HIGH_W'(max_acc);
      pk   = (top > base) ? bpt_pkg::PEAK_W'(top - base) : '0;
      peak = (pk > packet_peak_ff) ? pk : packet_peak_ff;

      thresh3    = (bpt_pkg::PEAK_W'(cfg.peak_threshold) << 1)
                 + bpt_pkg::PEAK_W'(cfg.peak_threshold);
      over       = peak > thresh3;
      hits_after = (over && (hit_count_ff < bpt_pkg::HIT_MAX)) ? hit_count_ff + 6'd1
                                                             : hit_count_ff;

      sample_index_in  = sample_index_ff;
      channel_index_in = channel_index_ff;
      low_sum_in       = low_sum_ff;
      high_sum_in      = high_sum_ff;
      chan_max_in      = chan_max_ff;
      packet_peak_in   = packet_peak_ff;
      hit_count_in     = hit_count_ff;

      if (step) begin
         if (!chan_done) begin
            sample_index_in = sample_index_ff + 5'd1;
            low_sum_in      = low_acc;
            high_sum_in     = high_acc;
            chan_max_in     = max_acc;
         end else begin
            // clear the channel, then advance or close the packet
            sample_index_in = '0;
            low_sum_in      = '0;
            high_sum_in     = '0;
            chan_max_in     = '0;
            if (!pkt_done) begin
               channel_index_in = channel_index_ff + 8'd1;
               packet_peak_in   = peak;
            end else begin
               channel_index_in = '0;
               packet_peak_in   = '0;
               hit_count_in     = last_pkt ? '0 : hits_after;
            end
         end
      end

      produce             = pkt_done;
      rsp.peak_thirds     = peak;
      rsp.over_threshold  = over;
      rsp.event_hit_count = last_pkt ? hits_after : '0;
      rsp.end_of_event    = last_pkt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff  <= '0;
         channel_index_ff <= '0;
         low_sum_ff       <= '0;
         high_sum_ff      <= '0;
         chan_max_ff      <= '0;
         packet_peak_ff   <= '0;
         hit_count_ff     <= '0;
      end else begin
         sample_index_ff  <= sample_index_in;
         channel_index_ff <= channel_index_in;
         low_sum_ff       <= low_sum_in;
         high_sum_ff      <= high_sum_in;
         chan_max_ff      <= chan_max_in;
         packet_peak_ff   <= packet_peak_in;
         hit_count_ff     <= hit_count_in;
      end
   end

endmodule

// ===== hw/rtl/bpt_rsp_buf.sv =====
// Result register that holds one item until the downstream side takes it.
module bpt_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  bpt_pkg::rsp_type load_data,
   output logic             space,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output bpt_pkg::rsp_type rsp_data
);

   logic             valid_ff, valid_in;
   bpt_pkg::rsp_type data_ff;

   assign space = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load)
         valid_in = 1'b1;
      else if (rsp_tready)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

endmodule

// ===== hw/rtl/baseline_peak_trigger_core.sv =====
// Top level of the baseline-subtracted packet peak trigger.
//
// Takes one converter sample per item, channel by channel and in sample order
// within a channel. Each channel's baseline is the lower of the mean of its
// first three and last three samples; the packet peak is the largest
// baseline-subtracted channel maximum, in thirds of a count. One result item
// leaves after each packet's final sample, flagged when the peak exceeds
// three times peak_threshold; on the event's last packet it also carries the
// number of packets over threshold. The block takes one item per cycle while no
// result waits on a full result register: each sample passes an input register,
// then the accumulate logic, which loads the result register with the result of
// the packet's final sample. The accumulate step only waits when a result is
// due and the result register is still full and not being read. Configuration
// writes take effect on the next cycle.
module baseline_peak_trigger_core (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,  // [13:0] adc_sample
   input  logic                           req_tlast,  // last_packet_of_event

   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,  // [15:0] peak_thirds,
                                                      // [21:16] event_hit_count
   output logic                           rsp_tuser,  // over_threshold
   output logic                           rsp_tlast,  // end_of_event

   input  logic                           csr_we,
   input  logic [bpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic                         in_valid_ff, in_valid_in;
   logic [bpt_pkg::SAMPLE_W-1:0] in_sample_ff;
   logic                         in_last_ff;

   bpt_pkg::cfg_type cfg;
   bpt_pkg::rsp_type step_rsp;
   bpt_pkg::rsp_type out_rsp;
   logic             produce;
   logic             space;
   logic             advance;
   logic             take;

   // advance the held item unless it closes a packet and the result slot is full and not being read
   assign advance    = in_valid_ff && (!produce || space);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_sample_ff <= req_tdata[bpt_pkg::SAMPLE_W-1:0];
         in_last_ff   <= req_tlast;
      end
   end

   bpt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpt_accum u_accum (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .sample   (in_sample_ff),
      .last_pkt (in_last_ff),
      .step     (advance),
      .produce  (produce),
      .rsp      (step_rsp)
   );

   bpt_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && produce),
      .load_data  (step_rsp),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (out_rsp)
   );

   assign rsp_tdata = {2'b00, out_rsp.event_hit_count, out_rsp.peak_thirds};
   assign rsp_tuser = out_rsp.over_threshold;
   assign rsp_tlast = out_rsp.end_of_event;

endmodule

// ===== tb/peak_result_checker.sv =====
// Checker for the baseline peak trigger: predicts each packet result and compares it.
`timescale 1ns / 1ps

module peak_result_checker
   import bpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [15:0]           req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [23:0]           rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           results_owed,
   output int unsigned           mismatches
);

   localparam int unsigned RING_DEPTH = 16;

   int unsigned samples_reg;
   int unsigned channels_reg;
   int unsigned threshold_reg;

   int unsigned pos_in_channel;
   int unsigned channel_no;
   int unsigned head_sum;
   int unsigned tail_sum;
   int unsigned channel_top;
   int unsigned packet_best;
   int unsigned event_hits;

   rsp_type     due_ring[RING_DEPTH];
   int unsigned due_wr;
   int unsigned due_rd;
   int unsigned miss_count = 0;

   assign mismatches = miss_count;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      miss_count++;
   endtask

   task automatic clear_channel();
      pos_in_channel = 0;
      head_sum       = 0;
      tail_sum       = 0;
      channel_top    = 0;
   endtask

   // Fold one accepted sample into the running channel and packet state.
   task automatic take_sample(input int unsigned adc, input bit closes_event);
      int unsigned span;
      int unsigned width;
      int unsigned base;
      int unsigned top_thirds;
      int unsigned peak16;
      bit          over;
      rsp_type     due;
      span = samples_reg;
      if (span < 32'(NSAMP_MIN)) span = 32'(NSAMP_MIN);
      if (span > MAX_SAMPLES) span = MAX_SAMPLES;
      width = channels_reg;
      if (width < 32'(NCHAN_MIN)) width = 32'(NCHAN_MIN);
      if (width > MAX_CHANNELS) width = MAX_CHANNELS;

      if (pos_in_channel < 3) head_sum += adc;
      if (pos_in_channel >= span - 3) tail_sum += adc;
      if (adc > channel_top) channel_top = adc;
      if (pos_in_channel + 1 < span) begin
         pos_in_channel++;
         return;
      end

      // channel done: baseline is the lower of the two three-sample sums
      base       = (head_sum < tail_sum) ? head_sum : tail_sum;
      top_thirds = 3 * channel_top;
      if (top_thirds > base && top_thirds - base > packet_best)
         packet_best = top_thirds - base;
      clear_channel();
      if (channel_no + 1 < width) begin
         channel_no++;
         return;
      end

      channel_no = 0;
      peak16     = packet_best & 16'hFFFF;
      over       = peak16 > 3 * threshold_reg;
      if (over && event_hits < HIT_LIMIT) event_hits++;
      due.peak_thirds     = peak16[PEAK_W-1:0];
      due.over_threshold  = over;
      due.event_hit_count = closes_event ? event_hits[HITS_W-1:0] : '0;
      due.end_of_event    = closes_event;
      due_ring[due_wr % RING_DEPTH] = due;
      due_wr++;
      if (closes_event) event_hits = 0;
      packet_best = 0;
   endtask

   task automatic check_result();
      rsp_type want;
      if (due_wr == due_rd) begin
         report("result with nothing due, peak_thirds", 32'(rsp_tdata[15:0]), 32'd0);
         return;
      end
      want = due_ring[due_rd % RING_DEPTH];
      due_rd++;
      if (rsp_tdata[15:0] !== want.peak_thirds)
         report("peak_thirds", 32'(rsp_tdata[15:0]), 32'(want.peak_thirds));
      if (rsp_tuser !== want.over_threshold)
         report("over_threshold", 32'(rsp_tuser), 32'(want.over_threshold));
      if (rsp_tdata[21:16] !== want.event_hit_count)
         report("event_hit_count", 32'(rsp_tdata[21:16]), 32'(want.event_hit_count));
      if (rsp_tlast !== want.end_of_event)
         report("end_of_event", 32'(rsp_tlast), 32'(want.end_of_event));
      if (rsp_tdata[23:22] !== 2'b00)
         report("tdata padding", 32'(rsp_tdata[23:22]), 32'd0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         samples_reg   = 32'(NSAMP_RESET);
         channels_reg  = 32'(NCHAN_RESET);
         threshold_reg = 32'(THRESH_RESET);
         clear_channel();
         channel_no  = 0;
         packet_best = 0;
         event_hits  = 0;
         due_wr      = 0;
         due_rd      = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SAMPLES_PER_CHANNEL: samples_reg   = 32'(csr_wdata[NSAMP_W-1:0]);
               CSR_CHANNELS_PER_PACKET: channels_reg  = 32'(csr_wdata[NCHAN_W-1:0]);
               CSR_PEAK_THRESHOLD:      threshold_reg = 32'(csr_wdata[THRESH_W-1:0]);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_sample(32'(req_tdata[SAMPLE_W-1:0]), req_tlast);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      results_owed <= due_wr - due_rd;
   end

endmodule

// ===== tb/tb_baseline_peak_trigger_core.sv =====
// Testbench top: drives samples and register writes into the peak trigger and gives the verdict.
`timescale 1ns / 1ps

module tb_baseline_peak_trigger_core;
   import bpt_pkg::*;

   localparam int unsigned SAMPLE_TOP   = (1 << SAMPLE_W) - 1;
   localparam int unsigned THRESH_TOP   = (1 << THRESH_W) - 1;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_SAMPLES_PER_CHANNEL;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int unsigned results_owed;
   int unsigned mismatches;
   int unsigned cycle_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned samples_eff   = NSAMP_RESET;
   int unsigned chans_eff     = NCHAN_RESET;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   baseline_peak_trigger_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   peak_result_checker peak_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .results_owed (results_owed),
      .mismatches   (mismatches)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_tready  <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic set_pressure(input int unsigned mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 68; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 68; end
         default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
   endtask

   task automatic send_item(input logic [SAMPLE_W-1:0] adc, input logic closes);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, adc};
      req_tlast  <= closes;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold input idle until every result is out, then let the pipeline drain.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_we high; the caller drops it after the last write of a batch.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Program all three registers; out-of-range raw values stand in for the clamps.
   task automatic program_regs(input int unsigned ns, input int unsigned nc,
                               input int unsigned thr);
      logic [CSR_DATA_W-1:0] junk;
      logic [NSAMP_W-1:0]    ns_raw;
      logic [NCHAN_W-1:0]    nc_raw;
      ns_raw = NSAMP_W'(ns);
      if (ns == NSAMP_MIN && $urandom_range(0, 1)) ns_raw = NSAMP_W'($urandom_range(0, 5));
      if (ns == MAX_SAMPLES && $urandom_range(0, 1)) ns_raw = NSAMP_W'($urandom_range(33, 63));
      nc_raw = NCHAN_W'(nc);
      if (nc == NCHAN_MIN && $urandom_range(0, 1)) nc_raw = '0;
      if (nc == MAX_CHANNELS && $urandom_range(0, 1))
         nc_raw = NCHAN_W'($urandom_range(257, 511));
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_SAMPLES_PER_CHANNEL, {junk[CSR_DATA_W-1:NSAMP_W], ns_raw});
      junk = CSR_DATA_W'($urandom);
      write_reg(CSR_CHANNELS_PER_PACKET, {junk[CSR_DATA_W-1:NCHAN_W], nc_raw});
      write_reg(CSR_PEAK_THRESHOLD, thr[CSR_DATA_W-1:0]);
      csr_we <= 1'b0;
      samples_eff = ns;
      chans_eff   = nc;
   endtask

   // Six-sample single-channel packet: flat level with one spike in the middle.
   task automatic send_spike(input int unsigned level, input int unsigned spike,
                             input bit closes);
      for (int k = 0; k < 6; k++)
         send_item(SAMPLE_W'((k == 3) ? spike : level),
                   (k == 5) ? closes : 1'($urandom_range(0, 1)));
   endtask

   task automatic send_packet(input bit closes_event, input int unsigned spike_floor);
      int unsigned style;
      int unsigned level;
      int unsigned spike_at;
      int unsigned spike;
      int unsigned adc;
      bit          final_item;
      style = $urandom_range(0, 7);
      for (int ch = 0; ch < chans_eff; ch++) begin
         level    = $urandom_range(0, 12000);
         spike_at = $urandom_range(0, samples_eff - 1);
         spike    = $urandom_range(spike_floor, 4000);
         for (int k = 0; k < samples_eff; k++) begin
            case (style)
               0: adc = $urandom_range(0, SAMPLE_TOP);
               1: adc = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
               default: begin
                  adc = level + $urandom_range(0, 15) + ((k == spike_at) ? spike : 0);
                  if (adc > SAMPLE_TOP) adc = SAMPLE_TOP;
               end
            endcase
            final_item = (ch == chans_eff - 1) && (k == samples_eff - 1);
            send_item(adc[SAMPLE_W-1:0],
                      final_item ? closes_event : 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin
      int unsigned ns;
      int unsigned nc;
      int unsigned thr;
      int unsigned sent;
      int unsigned packets;
      csr_index_type idx;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Threshold still at its reset value: one count above it hits, equal does not.
      write_reg(CSR_SAMPLES_PER_CHANNEL, CSR_DATA_W'(NSAMP_MIN));
      write_reg(CSR_CHANNELS_PER_PACKET, CSR_DATA_W'(NCHAN_MIN));
      csr_we <= 1'b0;
      samples_eff = NSAMP_MIN;
      chans_eff   = NCHAN_MIN;
      send_spike(0, THRESH_RESET + 1, 0);
      send_spike(0, THRESH_RESET, 1);
      settle();

      // Zero threshold, sample count below the floor: full-scale spike and flat top.
      write_reg(CSR_SAMPLES_PER_CHANNEL, '0);
      write_reg(CSR_PEAK_THRESHOLD, '0);
      csr_we <= 1'b0;
      send_spike(0, SAMPLE_TOP, 0);
      send_spike(SAMPLE_TOP, SAMPLE_TOP, 1);
      settle();

      // Largest threshold: even the largest peak is no hit.
      write_reg(CSR_PEAK_THRESHOLD, CSR_DATA_W'(THRESH_TOP));
      csr_we <= 1'b0;
      send_spike(0, SAMPLE_TOP, 1);
      settle();

      for (int phase = 0; phase < 8; phase++) begin
         set_pressure(phase % 4);
         case ($urandom_range(0, 9))
            0: ns = NSAMP_MIN;
            1: ns = MAX_SAMPLES;
            default: ns = $urandom_range(6, 12);
         endcase
         nc = ($urandom_range(0, 5) == 0) ? NCHAN_MIN : $urandom_range(1, 3);
         case ($urandom_range(0, 9))
            0: thr = 0;
            1: thr = THRESH_TOP;
            default: thr = $urandom_range(0, 4000);
         endcase
         program_regs(ns, nc, thr);
         sent = 0;
         while (sent < 24) begin
            packets = (samples_eff * chans_eff > 40) ? 1 : $urandom_range(1, 4);
            for (int p = 0; p < packets; p++) send_packet(p == packets - 1, 0);
            sent += samples_eff * chans_eff * packets;
         end
         settle();
      end

      // Long event of hits to drive the hit count into saturation, then one fresh event.
      set_pressure($urandom_range(0, 3));
      program_regs(NSAMP_MIN, NCHAN_MIN, 0);
      for (int p = 0; p < 38; p++) send_packet(p == 37, 50);
      send_packet(1, 0);
      settle();

      // Change registers partway through channels and packets.
      set_pressure(3);
      program_regs(12, 3, $urandom_range(0, 4000));
      for (int round = 0; round < 6; round++) begin
         repeat ($urandom_range(4, 20))
            send_item(SAMPLE_W'($urandom_range(0, SAMPLE_TOP)), 1'($urandom_range(0, 1)));
         settle();
         idx = csr_index_type'($urandom_range(0, 2));
         case (idx)
            CSR_SAMPLES_PER_CHANNEL: write_reg(idx, CSR_DATA_W'($urandom_range(0, 40)));
            CSR_CHANNELS_PER_PACKET: write_reg(idx, CSR_DATA_W'($urandom_range(0, 4)));
            default:                 write_reg(idx, CSR_DATA_W'($urandom_range(0, THRESH_TOP)));
         endcase
         csr_we <= 1'b0;
      end
      repeat ($urandom_range(20, 60))
         send_item(SAMPLE_W'($urandom_range(0, SAMPLE_TOP)), 1'($urandom_range(0, 1)));
      settle();

      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
